@@ sv/ccinc_pkg.sv @@
// Shared types, field widths and calendar constants for the calendar clock
// increment unit. No dependencies; every other file in this block imports it.

package ccinc_pkg;

   localparam int YEAR_W    = 14;
   localparam int MONTH_W   = 7;
   localparam int DAY_W     = 7;
   localparam int WEEKDAY_W = 4;
   localparam int HOUR_W    = 7;
   localparam int MINUTE_W  = 7;
   localparam int SECOND_W  = 7;
   localparam int MLEN_W    = 5;

   localparam logic [SECOND_W-1:0]  SECOND_LAST  = SECOND_W'(59);
   localparam logic [MINUTE_W-1:0]  MINUTE_LAST  = MINUTE_W'(59);
   localparam logic [HOUR_W-1:0]    HOUR_LAST    = HOUR_W'(23);
   localparam logic [HOUR_W-1:0]    HOURS_PER_DAY = HOUR_W'(24);
   localparam logic [WEEKDAY_W-1:0] WEEKDAY_LAST = WEEKDAY_W'(7);
   localparam logic [WEEKDAY_W-1:0] WEEKDAY_FIRST = WEEKDAY_W'(1);
   localparam logic [DAY_W-1:0]     DAY_FIRST    = DAY_W'(1);
   localparam logic [MONTH_W-1:0]   MONTH_LAST   = MONTH_W'(12);
   localparam logic [MONTH_W-1:0]   MONTH_FIRST  = MONTH_W'(1);
   localparam logic [YEAR_W-1:0]    YEAR_LAST    = YEAR_W'(9999);

   localparam logic [MLEN_W-1:0] LEN_LONG  = MLEN_W'(31);
   localparam logic [MLEN_W-1:0] LEN_SHORT = MLEN_W'(30);
   localparam logic [MLEN_W-1:0] LEN_FEB_LEAP = MLEN_W'(29);
   localparam logic [MLEN_W-1:0] LEN_FEB   = MLEN_W'(28);
   localparam logic [MLEN_W-1:0] LEN_NONE  = MLEN_W'(0);

   typedef struct packed {
      logic [YEAR_W-1:0]    year;
      logic [MONTH_W-1:0]   month;
      logic [DAY_W-1:0]     day;
      logic [WEEKDAY_W-1:0] weekday;
      logic [HOUR_W-1:0]    hour;
      logic [MINUTE_W-1:0]  minute;
      logic [SECOND_W-1:0]  second;
   } calendar_type;

   typedef struct packed {
      logic input_legal;
      logic month_error;
   } status_type;

   // Days in the given month; zero for a month outside 1 to 12.
   function automatic logic [MLEN_W-1:0] month_length(input logic [MONTH_W-1:0] month,
                                                      input logic leap);
      logic [MLEN_W-1:0] len;
      case (month) inside
         7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: len = LEN_LONG;
         7'd4, 7'd6, 7'd9, 7'd11:                    len = LEN_SHORT;
         7'd2:    len = leap ? LEN_FEB_LEAP : LEN_FEB;
         default: len = LEN_NONE;
      endcase
      return len;
   endfunction

endpackage

@@ sv/ccinc_leap.sv @@
// Gregorian leap year detection for a 14-bit binary year.
// Depends on ccinc_pkg.

module ccinc_leap (
   input  logic [ccinc_pkg::YEAR_W-1:0] year,
   output logic                         leap
);
   import ccinc_pkg::*;

   // The quotient by 100 comes from a reciprocal multiply: 5243 / 2^19 is
   // close enough to 1/100 that the floor is exact for every 14-bit year.
   localparam int RECIP_SHIFT = 19;
   localparam int RECIP_W     = 13;
   localparam int QUOT_W      = 8;
   localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'(5243);

   logic [YEAR_W+RECIP_W-1:0] product;
   logic [QUOT_W-1:0]         quotient;
   logic [YEAR_W-1:0]         hundreds;
   logic                      century;

   assign product  = YEAR_W'(year) * RECIP_100;
   assign quotient = product[RECIP_SHIFT +: QUOT_W];
   // Times 100 as shifts and adds: 64 + 32 + 4.
   assign hundreds = YEAR_W'({quotient, 6'b0}) + YEAR_W'({quotient, 5'b0})
                   + YEAR_W'({quotient, 2'b0});
   assign century  = (hundreds == year);

   // A century year is a leap year only when it is also a multiple of 400.
   assign leap = (year[1:0] == 2'b00) && (!century || (quotient[1:0] == 2'b00));

endmodule

@@ sv/ccinc_step.sv @@
// Combinational one-second advance of a calendar time with ripple carry,
// plus the legality and bad-month flags. Depends on ccinc_pkg and ccinc_leap.

module ccinc_step (
   input  ccinc_pkg::calendar_type now,
   output ccinc_pkg::calendar_type next,
   output ccinc_pkg::status_type   status
);
   import ccinc_pkg::*;

   logic              leap;
   logic [MLEN_W-1:0] len;
   logic              len_ok;
   logic              carry_sec;
   logic              carry_min;
   logic              carry_hour;
   logic              carry_day;
   logic              carry_month;

   ccinc_leap u_leap (
      .year (now.year),
      .leap (leap)
   );

   assign len    = month_length(now.month, leap);
   assign len_ok = (len != LEN_NONE);

   assign status.input_legal = (now.hour < HOURS_PER_DAY) && len_ok
                             && (now.day <= DAY_W'(len));
   // A wrapping hour that meets an unknown month stops the carry there.
   assign status.month_error = carry_hour && !len_ok;

   assign carry_sec   = (now.second >= SECOND_LAST);
   assign carry_min   = carry_sec && (now.minute >= MINUTE_LAST);
   assign carry_hour  = carry_min && (now.hour >= HOUR_LAST);
   assign carry_day   = carry_hour && len_ok && (now.day >= DAY_W'(len));
   assign carry_month = carry_day && (now.month >= MONTH_LAST);

   always_comb begin
      next = now;
      next.second = carry_sec ? '0 : now.second + SECOND_W'(1);
      if (carry_sec) begin
         next.minute = carry_min ? '0 : now.minute + MINUTE_W'(1);
      end
      if (carry_min) begin
         next.hour = carry_hour ? '0 : now.hour + HOUR_W'(1);
      end
      if (carry_hour) begin
         next.weekday = (now.weekday >= WEEKDAY_LAST) ? WEEKDAY_FIRST
                                                      : now.weekday + WEEKDAY_W'(1);
         if (len_ok) begin
            next.day = carry_day ? DAY_FIRST : now.day + DAY_W'(1);
         end
      end
      if (carry_day) begin
         next.month = carry_month ? MONTH_FIRST : now.month + MONTH_W'(1);
      end
      if (carry_month) begin
         next.year = (now.year >= YEAR_LAST) ? '0 : now.year + YEAR_W'(1);
      end
   end

endmodule

@@ sv/calendar_clock_increment_unit.sv @@
// Top level of the calendar clock increment unit: request register, the
// one-second advance and the result register. Depends on ccinc_pkg, ccinc_step.
//
// A request is taken at every clock edge at which start is high; busy is
// never raised, so one request can be issued every cycle. Each request gives
// exactly one result; it is held in the request register and then passes
// through the advance logic into the result register. The result is shown
// for a single cycle with rsp_valid high and cannot be held off, so the
// receiver must take it then. Illegal inputs are still advanced;
// rsp_input_legal and rsp_month_error report the fault alongside the result.

module calendar_clock_increment_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [ccinc_pkg::YEAR_W-1:0]    req_year_in,
   input  logic [ccinc_pkg::MONTH_W-1:0]   req_month_in,
   input  logic [ccinc_pkg::DAY_W-1:0]     req_day_in,
   input  logic [ccinc_pkg::WEEKDAY_W-1:0] req_weekday_in,
   input  logic [ccinc_pkg::HOUR_W-1:0]    req_hour_in,
   input  logic [ccinc_pkg::MINUTE_W-1:0]  req_minute_in,
   input  logic [ccinc_pkg::SECOND_W-1:0]  req_second_in,
   output logic                            rsp_valid,
   output logic [ccinc_pkg::YEAR_W-1:0]    rsp_year_out,
   output logic [ccinc_pkg::MONTH_W-1:0]   rsp_month_out,
   output logic [ccinc_pkg::DAY_W-1:0]     rsp_day_out,
   output logic [ccinc_pkg::WEEKDAY_W-1:0] rsp_weekday_out,
   output logic [ccinc_pkg::HOUR_W-1:0]    rsp_hour_out,
   output logic [ccinc_pkg::MINUTE_W-1:0]  rsp_minute_out,
   output logic [ccinc_pkg::SECOND_W-1:0]  rsp_second_out,
   output logic                            rsp_input_legal,
   output logic                            rsp_month_error
);
   import ccinc_pkg::*;

   logic         req_accept;
   logic         req_valid_ff;
   logic         req_valid_in;
   calendar_type req_ff;
   calendar_type req_in;
   calendar_type next_time;
   status_type   next_status;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   calendar_type rsp_ff;
   status_type   status_ff;

   assign busy       = 1'b0;
   assign req_accept = start && !busy;

   assign req_valid_in = req_accept;
   assign req_in = '{year:    req_year_in,
                     month:   req_month_in,
                     day:     req_day_in,
                     weekday: req_weekday_in,
                     hour:    req_hour_in,
                     minute:  req_minute_in,
                     second:  req_second_in};

   ccinc_step u_step (
      .now    (req_ff),
      .next   (next_time),
      .status (next_status)
   );

   assign rsp_valid_in = req_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers load only with a request, so they need no reset.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_ff <= req_in;
      end
      if (req_valid_ff) begin
         rsp_ff    <= next_time;
         status_ff <= next_status;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_year_out    = rsp_ff.year;
   assign rsp_month_out   = rsp_ff.month;
   assign rsp_day_out     = rsp_ff.day;
   assign rsp_weekday_out = rsp_ff.weekday;
   assign rsp_hour_out    = rsp_ff.hour;
   assign rsp_minute_out  = rsp_ff.minute;
   assign rsp_second_out  = rsp_ff.second;
   assign rsp_input_legal = status_ff.input_legal;
   assign rsp_month_error = status_ff.month_error;

   // Every request yields its result after the request and result registers.
   a_latency : assert property (@(posedge clock) disable iff (reset)
      req_accept |-> ##2 rsp_valid)
      else $error("request did not produce a result two cycles later");

   // A bad month cannot be reported for a legal input.
   a_flags : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_month_error) |-> !rsp_input_legal)
      else $error("month error reported on a legal input");

   // The advanced second always lies in 0 to 59.
   a_second : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_second_out <= SECOND_LAST))
      else $error("second out of range after advance");

   // A month error stops the carry, so the day passes through unchanged.
   a_merr_day : assert property (@(posedge clock) disable iff (reset)
      (req_valid_ff && next_status.month_error) |-> (next_time.day == req_ff.day))
      else $error("day changed despite a month error");

endmodule
